[hdl/tmcg_pkg.sv]
// ============================================================================
// tmcg_pkg - shared definitions for the text-mode character generator
// Geometry, field widths, reset values, item kinds and the command/status
// bundles that join the controller and the datapath.
// ============================================================================
package tmcg_pkg;

    // Screen geometry
    localparam int COLS        = 32;
    localparam int ROWS        = 24;
    localparam int COL_W       = $clog2(COLS);
    localparam int ROW_W       = $clog2(ROWS);
    localparam int SCR_DEPTH   = COLS * ROWS;
    localparam int SCR_AW      = $clog2(SCR_DEPTH);
    localparam int ISSUE_W     = $clog2(COLS + 1);

    // Font geometry
    localparam int CODE_W      = 8;
    localparam int SLICE_W     = 3;
    localparam int SLICES      = 8;
    localparam int GLYPH_AW    = CODE_W + SLICE_W;
    localparam int GLYPH_DEPTH = 2 ** GLYPH_AW;
    localparam int VIS_LINES   = ROWS * SLICES;

    // Field and port widths
    localparam int LINE_W      = 9;
    localparam int SYNC_W      = 12;
    localparam int POS_W       = 5;
    localparam int KIND_W      = 3;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    // Register reset values
    localparam logic [LINE_W-1:0] FIRST_VISIBLE_RST = 9'd40;
    localparam logic [LINE_W-1:0] LAST_LINE_RST     = 9'd262;
    localparam logic [LINE_W-1:0] VSYNC_FIRST_RST   = 9'd3;
    localparam logic [LINE_W-1:0] VSYNC_LAST_RST    = 9'd5;
    localparam logic [SYNC_W-1:0] SHORT_SYNC_RST    = 12'd225;
    localparam logic [SYNC_W-1:0] LONG_SYNC_RST     = 12'd2825;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VISIBLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_LINE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_LAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SYNC    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SYNC     = 3'd5;

    // Input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_PRINT  = 3'd1,
        KIND_CURSOR = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_SCROLL = 3'd4,
        KIND_FONT   = 3'd5,
        KIND_CELL   = 3'd6
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic tick_start;
        logic set_cursor;
        logic clear;
        logic scroll;
        logic font_wr;
        logic target_load;
        logic target_print;
        logic issue;
        logic fill;
        logic cell_wr;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  cell_in_range;
        logic  issue_last;
        logic  advance;
        logic  pipe_empty;
        logic  row_valid;
        logic  fill_done;
    } sts_t;

endpackage

[hdl/text_mode_video_character_generator.sv]
// ============================================================================
// text_mode_video_character_generator - text-mode scanline generator
// 32x24 character screen and 256-glyph, 8-row font rendered one scanline
// per line tick, with print, cursor, clear, scroll and store writes.
// ============================================================================
// One item is worked on at a time. A line tick on a visible line gives 33
// result transactions, one per cycle while m_tready stays high; the screen
// RAM read and the glyph RAM read that follows it are registered stages
// ahead of the output register, and the block waits for that pipeline to
// empty. A tick on a blank line gives one result transaction. Print and cell
// write go through check and write states, and the target row is first
// zero-filled through the single screen write port when it has been blanked
// by reset, clear or scroll since it was last written. Set cursor, clear,
// scroll and font write complete without leaving the idle state. A finished
// result may wait in the output register while the next item is taken.
// Clear and scroll cost no sweep: rows are kept in a circular order with one
// valid bit per row, so reset needs no clearing pass. Font bytes never
// written read back as unknown.
module text_mode_video_character_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [tmcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmcg_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code[7:0], col[12:8], row[17:13], font_addr[28:18],
    // font_data[36:29], zero [39:37]
    input  logic [tmcg_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind[2:0]
    input  logic [tmcg_pkg::KIND_W-1:0]     s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_number[8:0], sync_width[20:9], pattern[28:21], zero [31:29]
    output logic [tmcg_pkg::OUT_DATA_W-1:0] m_tdata,
    // pixel_valid[0]
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast
);

    tmcg_pkg::cmd_t cmd;
    tmcg_pkg::sts_t sts;

    tmcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmcg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // new items only enter with the render pipeline empty
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> sts.pipe_empty)
        else $error("item accepted while render pipeline busy");

    // a line tick holds off the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == tmcg_pkg::KIND_TICK)) |=> !s_tready)
        else $error("input ready right after a line tick");

    // blank line result is a single zero byte marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[28:21] == 8'h00)))
        else $error("blank line result malformed");

    // zero-fill only runs on a row that reads as blank
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> !sts.row_valid)
        else $error("zero-fill on a row already in use");

endmodule

[hdl/tmcg_ram.sv]
// ============================================================================
// tmcg_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
module tmcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tmcg_ctrl.sv]
// ============================================================================
// tmcg_ctrl - sequencer for the text-mode character generator
// Decodes each accepted item and steps the datapath through scanline
// issue, pipeline drain, row zero-fill and cell write.
// ============================================================================
module tmcg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tmcg_pkg::sts_t  sts,
    output tmcg_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TICK  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_FILL  = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (sts.kind)
                        tmcg_pkg::KIND_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            state_next     = ST_TICK;
                        end
                        tmcg_pkg::KIND_PRINT:
                        begin
                            cmd.target_load  = 1'b1;
                            cmd.target_print = 1'b1;
                            state_next       = ST_CHECK;
                        end
                        tmcg_pkg::KIND_CURSOR: cmd.set_cursor = 1'b1;
                        tmcg_pkg::KIND_CLEAR:  cmd.clear      = 1'b1;
                        tmcg_pkg::KIND_SCROLL: cmd.scroll     = 1'b1;
                        tmcg_pkg::KIND_FONT:   cmd.font_wr    = 1'b1;
                        tmcg_pkg::KIND_CELL:
                        begin
                            // out-of-range cell writes are dropped
                            if (sts.cell_in_range)
                            begin
                                cmd.target_load = 1'b1;
                                state_next      = ST_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_TICK:
            begin
                cmd.issue = 1'b1;
                if (sts.advance && sts.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.row_valid ? ST_WRITE : ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.cell_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/tmcg_dp.sv]
// ============================================================================
// tmcg_dp - datapath for the text-mode character generator
// Registers, line counter, cursor, circular screen rows with row valid bits,
// screen and glyph RAMs, the render pipeline stages s1 and s2 and output register.
// ============================================================================
module tmcg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tmcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmcg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [tmcg_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [tmcg_pkg::KIND_W-1:0]         s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [tmcg_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  tmcg_pkg::cmd_t                      cmd,
    output tmcg_pkg::sts_t                      sts
);

    localparam int COL_W   = tmcg_pkg::COL_W;
    localparam int ROW_W   = tmcg_pkg::ROW_W;
    localparam int SCR_AW  = tmcg_pkg::SCR_AW;
    localparam int LINE_W  = tmcg_pkg::LINE_W;
    localparam int SYNC_W  = tmcg_pkg::SYNC_W;
    localparam int CODE_W  = tmcg_pkg::CODE_W;
    localparam int SLICE_W = tmcg_pkg::SLICE_W;
    localparam int ISSUE_W = tmcg_pkg::ISSUE_W;
    localparam int POS_W   = tmcg_pkg::POS_W;
    localparam int ROWS    = tmcg_pkg::ROWS;
    localparam int COLS    = tmcg_pkg::COLS;

    // logical row plus scroll base, wrapped to the screen height
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [SCR_AW-1:0] scr_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
        return SCR_AW'(prow) * SCR_AW'(COLS) + SCR_AW'(col);
    endfunction

    // input fields
    logic [CODE_W-1:0]  in_code;
    logic [POS_W-1:0]   in_col;
    logic [POS_W-1:0]   in_row;
    logic [tmcg_pkg::GLYPH_AW-1:0] in_faddr;
    logic [CODE_W-1:0]  in_fdata;

    assign in_code  = s_tdata[7:0];
    assign in_col   = s_tdata[12:8];
    assign in_row   = s_tdata[17:13];
    assign in_faddr = s_tdata[28:18];
    assign in_fdata = s_tdata[36:29];

    // control registers
    logic [LINE_W-1:0] first_visible_reg, first_visible_next;
    logic [LINE_W-1:0] last_line_reg,     last_line_next;
    logic [LINE_W-1:0] vsync_first_reg,   vsync_first_next;
    logic [LINE_W-1:0] vsync_last_reg,    vsync_last_next;
    logic [SYNC_W-1:0] short_sync_reg,    short_sync_next;
    logic [SYNC_W-1:0] long_sync_reg,     long_sync_next;
    logic [LINE_W-1:0] line_counter_reg,  line_counter_next;
    logic [COL_W-1:0]  cur_col_reg,       cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg,       cur_row_next;
    logic [ROW_W-1:0]  base_reg,          base_next;
    logic [ROWS-1:0]   row_vld_reg,       row_vld_next;
    logic              s1_v_reg,          s1_v_next;
    logic              s2_v_reg,          s2_v_next;
    logic              out_v_reg,         out_v_next;

    // payload registers
    logic [LINE_W-1:0]  tick_ln_reg,    tick_ln_next;
    logic [SYNC_W-1:0]  tick_sw_reg,    tick_sw_next;
    logic [ISSUE_W-1:0] x_reg,          x_next;
    logic [COL_W-1:0]   tgt_col_reg,    tgt_col_next;
    logic [ROW_W-1:0]   tgt_row_reg,    tgt_row_next;
    logic [CODE_W-1:0]  tgt_code_reg,   tgt_code_next;
    logic               tgt_print_reg,  tgt_print_next;
    logic [COL_W-1:0]   fill_cnt_reg,   fill_cnt_next;
    logic               s1_trail_reg,   s1_trail_next;
    logic               s1_vis_reg,     s1_vis_next;
    logic               s1_rowok_reg,   s1_rowok_next;
    logic               s2_trail_reg,   s2_trail_next;
    logic               s2_vis_reg,     s2_vis_next;
    logic [LINE_W-1:0]  out_ln_reg,     out_ln_next;
    logic [SYNC_W-1:0]  out_sw_reg,     out_sw_next;
    logic               out_pix_reg,    out_pix_next;
    logic [CODE_W-1:0]  out_pat_reg,    out_pat_next;
    logic               out_last_reg,   out_last_next;

    // derived signals
    logic [LINE_W-1:0]  lc_inc;
    logic [SYNC_W-1:0]  sync_sel;
    logic [LINE_W-1:0]  rel_line;
    logic               vis_k;
    logic [ROW_W-1:0]   prow_k;
    logic [SLICE_W-1:0] slice_k;
    logic               row_ok_k;
    logic               trail_k;
    logic [ROW_W-1:0]   prow_t;
    logic               fill_done;
    logic               advance;
    logic               wrap_col;
    logic               do_scroll;
    logic [CODE_W-1:0]  scr_rdata;
    logic [CODE_W-1:0]  glyph_rdata;
    logic [CODE_W-1:0]  s1_char;

    // line counter step and sync width for the tick being accepted
    assign lc_inc   = line_counter_reg + LINE_W'(1);
    assign sync_sel = (lc_inc >= vsync_first_reg && lc_inc <= vsync_last_reg)
                      ? long_sync_reg : short_sync_reg;

    // visible window decode for the current tick
    assign rel_line = tick_ln_reg - first_visible_reg;
    assign vis_k    = (tick_ln_reg >= first_visible_reg) &&
                      ({1'b0, rel_line} < (LINE_W + 1)'(tmcg_pkg::VIS_LINES));
    assign prow_k   = phys_row(ROW_W'(rel_line >> SLICE_W), base_reg);
    assign slice_k  = rel_line[SLICE_W-1:0];
    assign row_ok_k = vis_k && row_vld_reg[prow_k];
    assign trail_k  = !vis_k || (x_reg == ISSUE_W'(COLS));

    // cell write target
    assign prow_t    = phys_row(tgt_row_reg, base_reg);
    assign fill_done = (fill_cnt_reg == COL_W'(COLS - 1));
    assign wrap_col  = (tgt_col_reg == COL_W'(COLS - 1));
    assign do_scroll = cmd.scroll ||
                       (cmd.cell_wr && tgt_print_reg && wrap_col &&
                        (tgt_row_reg == ROW_W'(ROWS - 1)));

    // pipeline moves whenever the output register is free
    assign advance = !out_v_reg || m_tready;
    assign s1_char = s1_rowok_reg ? scr_rdata : '0;

    // screen store, rows addressed through the scroll base
    tmcg_ram #(
        .WIDTH (CODE_W),
        .DEPTH (tmcg_pkg::SCR_DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (cmd.fill || cmd.cell_wr),
        .waddr (scr_addr(prow_t, cmd.fill ? fill_cnt_reg : tgt_col_reg)),
        .wdata (cmd.fill ? '0 : tgt_code_reg),
        .re    (advance),
        .raddr (scr_addr(prow_k, x_reg[COL_W-1:0])),
        .rdata (scr_rdata)
    );

    // glyph store
    tmcg_ram #(
        .WIDTH (CODE_W),
        .DEPTH (tmcg_pkg::GLYPH_DEPTH)
    ) u_glyph (
        .clk   (clk),
        .we    (cmd.font_wr),
        .waddr (in_faddr),
        .wdata (in_fdata),
        .re    (advance),
        .raddr ({s1_char, slice_k}),
        .rdata (glyph_rdata)
    );

    // next-state logic
    always_comb
    begin
        first_visible_next = first_visible_reg;
        last_line_next     = last_line_reg;
        vsync_first_next   = vsync_first_reg;
        vsync_last_next    = vsync_last_reg;
        short_sync_next    = short_sync_reg;
        long_sync_next     = long_sync_reg;
        line_counter_next  = line_counter_reg;
        cur_col_next       = cur_col_reg;
        cur_row_next       = cur_row_reg;
        base_next          = base_reg;
        row_vld_next       = row_vld_reg;
        s1_v_next          = s1_v_reg;
        s2_v_next          = s2_v_reg;
        out_v_next         = out_v_reg;
        tick_ln_next       = tick_ln_reg;
        tick_sw_next       = tick_sw_reg;
        x_next             = x_reg;
        tgt_col_next       = tgt_col_reg;
        tgt_row_next       = tgt_row_reg;
        tgt_code_next      = tgt_code_reg;
        tgt_print_next     = tgt_print_reg;
        fill_cnt_next      = fill_cnt_reg;
        s1_trail_next      = s1_trail_reg;
        s1_vis_next        = s1_vis_reg;
        s1_rowok_next      = s1_rowok_reg;
        s2_trail_next      = s2_trail_reg;
        s2_vis_next        = s2_vis_reg;
        out_ln_next        = out_ln_reg;
        out_sw_next        = out_sw_reg;
        out_pix_next       = out_pix_reg;
        out_pat_next       = out_pat_reg;
        out_last_next      = out_last_reg;

        // register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                tmcg_pkg::CFG_FIRST_VISIBLE: first_visible_next = cfg_data[LINE_W-1:0];
                tmcg_pkg::CFG_LAST_LINE:     last_line_next     = cfg_data[LINE_W-1:0];
                tmcg_pkg::CFG_VSYNC_FIRST:   vsync_first_next   = cfg_data[LINE_W-1:0];
                tmcg_pkg::CFG_VSYNC_LAST:    vsync_last_next    = cfg_data[LINE_W-1:0];
                tmcg_pkg::CFG_SHORT_SYNC:    short_sync_next    = cfg_data;
                tmcg_pkg::CFG_LONG_SYNC:     long_sync_next     = cfg_data;
                default: ;
            endcase
        end

        // line tick start: step counter, wrap past last line
        if (cmd.tick_start)
        begin
            tick_ln_next      = lc_inc;
            tick_sw_next      = sync_sel;
            x_next            = '0;
            line_counter_next = (lc_inc > last_line_reg) ? '0 : lc_inc;
        end

        // set cursor, saturated to the screen
        if (cmd.set_cursor)
        begin
            cur_col_next = (int'(in_col) >= COLS) ? COL_W'(COLS - 1) : COL_W'(in_col);
            cur_row_next = (int'(in_row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(in_row);
        end

        // clear: every row reads as blank
        if (cmd.clear)
        begin
            row_vld_next = '0;
        end

        // scroll: old top row becomes the blank bottom row
        if (do_scroll)
        begin
            base_next              = (base_reg == ROW_W'(ROWS - 1)) ? '0 : base_reg + 1'b1;
            row_vld_next[base_reg] = 1'b0;
        end

        // latch the cell target
        if (cmd.target_load)
        begin
            tgt_col_next   = cmd.target_print ? cur_col_reg : COL_W'(in_col);
            tgt_row_next   = cmd.target_print ? cur_row_reg : ROW_W'(in_row);
            tgt_code_next  = in_code;
            tgt_print_next = cmd.target_print;
            fill_cnt_next  = '0;
        end

        // zero-fill a blank row before its first write
        if (cmd.fill)
        begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
            if (fill_done)
            begin
                row_vld_next[prow_t] = 1'b1;
            end
        end

        // cursor advance after a printed character
        if (cmd.cell_wr && tgt_print_reg)
        begin
            if (wrap_col)
            begin
                cur_col_next = '0;
                if (tgt_row_reg != ROW_W'(ROWS - 1))
                begin
                    cur_row_next = tgt_row_reg + 1'b1;
                end
            end
            else
            begin
                cur_col_next = tgt_col_reg + 1'b1;
            end
        end

        // render pipeline and output register
        if (advance)
        begin
            s1_v_next     = cmd.issue;
            s1_trail_next = trail_k;
            s1_vis_next   = vis_k;
            s1_rowok_next = row_ok_k;
            if (cmd.issue)
            begin
                x_next = x_reg + 1'b1;
            end
            s2_v_next     = s1_v_reg;
            s2_trail_next = s1_trail_reg;
            s2_vis_next   = s1_vis_reg;
            out_v_next    = s2_v_reg;
            if (s2_v_reg)
            begin
                out_ln_next   = tick_ln_reg;
                out_sw_next   = tick_sw_reg;
                out_pix_next  = s2_vis_reg;
                out_pat_next  = s2_trail_reg ? '0 : glyph_rdata;
                out_last_next = s2_trail_reg;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_visible_reg <= tmcg_pkg::FIRST_VISIBLE_RST;
            last_line_reg     <= tmcg_pkg::LAST_LINE_RST;
            vsync_first_reg   <= tmcg_pkg::VSYNC_FIRST_RST;
            vsync_last_reg    <= tmcg_pkg::VSYNC_LAST_RST;
            short_sync_reg    <= tmcg_pkg::SHORT_SYNC_RST;
            long_sync_reg     <= tmcg_pkg::LONG_SYNC_RST;
            line_counter_reg  <= '0;
            cur_col_reg       <= '0;
            cur_row_reg       <= '0;
            base_reg          <= '0;
            row_vld_reg       <= '0;
            s1_v_reg          <= 1'b0;
            s2_v_reg          <= 1'b0;
            out_v_reg         <= 1'b0;
        end
        else
        begin
            first_visible_reg <= first_visible_next;
            last_line_reg     <= last_line_next;
            vsync_first_reg   <= vsync_first_next;
            vsync_last_reg    <= vsync_last_next;
            short_sync_reg    <= short_sync_next;
            long_sync_reg     <= long_sync_next;
            line_counter_reg  <= line_counter_next;
            cur_col_reg       <= cur_col_next;
            cur_row_reg       <= cur_row_next;
            base_reg          <= base_next;
            row_vld_reg       <= row_vld_next;
            s1_v_reg          <= s1_v_next;
            s2_v_reg          <= s2_v_next;
            out_v_reg         <= out_v_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        tick_ln_reg   <= tick_ln_next;
        tick_sw_reg   <= tick_sw_next;
        x_reg         <= x_next;
        tgt_col_reg   <= tgt_col_next;
        tgt_row_reg   <= tgt_row_next;
        tgt_code_reg  <= tgt_code_next;
        tgt_print_reg <= tgt_print_next;
        fill_cnt_reg  <= fill_cnt_next;
        s1_trail_reg  <= s1_trail_next;
        s1_vis_reg    <= s1_vis_next;
        s1_rowok_reg  <= s1_rowok_next;
        s2_trail_reg  <= s2_trail_next;
        s2_vis_reg    <= s2_vis_next;
        out_ln_reg    <= out_ln_next;
        out_sw_reg    <= out_sw_next;
        out_pix_reg   <= out_pix_next;
        out_pat_reg   <= out_pat_next;
        out_last_reg  <= out_last_next;
    end

    // status
    assign sts.kind          = tmcg_pkg::kind_t'(s_tuser);
    assign sts.cell_in_range = (int'(in_col) < COLS) && (int'(in_row) < ROWS);
    assign sts.issue_last    = trail_k;
    assign sts.advance       = advance;
    assign sts.pipe_empty    = !s1_v_reg && !s2_v_reg;
    assign sts.row_valid     = row_vld_reg[prow_t];
    assign sts.fill_done     = fill_done;

    // result port
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'b000, out_pat_reg, out_sw_reg, out_ln_reg};
    assign m_tuser  = out_pix_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sim/tb_text_mode_video_character_generator.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_text_mode_video_character_generator - scanline generator testbench
// Drives print, cursor, clear, scroll, cell and font transactions plus line
// ticks into the generator and checks every emitted scanline byte against a
// behavioral copy of the screen, font, cursor and line counter state. Timing
// registers are reprogrammed between phases.
// ============================================================================
module tb_text_mode_video_character_generator;
    import tmcg_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_GAP      = 12;
    localparam int MAX_REPORTS  = 100;
    localparam int BASE_COUNT   = 4;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    // glyphs loaded before anything can reach the screen
    localparam logic [BASE_COUNT-1:0][CODE_W-1:0] BASE_CODES =
        {8'hF0, 8'hAA, 8'h55, 8'h00};

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CODE_W-1:0]   char_code;
        logic [POS_W-1:0]    col;
        logic [POS_W-1:0]    row;
        logic [GLYPH_AW-1:0] font_addr;
        logic [7:0]          font_data;
    } char_item_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [SYNC_W-1:0] sync_width;
        logic              pixel_valid;
        logic [7:0]        pattern;
        logic              last_item;
    } scan_byte_t;

    // ------------------------------------------------------------------------
    // Screen/font state copy and the queue of scanline bytes still owed
    // ------------------------------------------------------------------------
    class scanline_board;
        logic [LINE_W-1:0] first_vis, last_line, vs_first, vs_last;
        logic [SYNC_W-1:0] short_sync, long_sync;
        logic [LINE_W-1:0] line_cnt;
        int                cur_col, cur_row;
        logic [CODE_W-1:0] screen [SCR_DEPTH];
        logic [7:0]        glyph [GLYPH_DEPTH];
        bit                glyph_set [GLYPH_DEPTH];
        scan_byte_t        expected_bytes [$];
        int                errors;

        function new();
            first_vis  = FIRST_VISIBLE_RST;
            last_line  = LAST_LINE_RST;
            vs_first   = VSYNC_FIRST_RST;
            vs_last    = VSYNC_LAST_RST;
            short_sync = SHORT_SYNC_RST;
            long_sync  = LONG_SYNC_RST;
            line_cnt   = '0;
            cur_col    = 0;
            cur_row    = 0;
            errors     = 0;
            foreach (screen[i]) screen[i] = '0;
            foreach (glyph[i])
            begin
                glyph[i]     = '0;
                glyph_set[i] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FIRST_VISIBLE: first_vis  = val[LINE_W-1:0];
                CFG_LAST_LINE:     last_line  = val[LINE_W-1:0];
                CFG_VSYNC_FIRST:   vs_first   = val[LINE_W-1:0];
                CFG_VSYNC_LAST:    vs_last    = val[LINE_W-1:0];
                CFG_SHORT_SYNC:    short_sync = val[SYNC_W-1:0];
                CFG_LONG_SYNC:     long_sync  = val[SYNC_W-1:0];
                default: ;
            endcase
        endfunction

        // a code may go on screen only once all its slices hold data
        function bit code_ready(logic [CODE_W-1:0] c);
            for (int s = 0; s < SLICES; s++)
                if (!glyph_set[{c, s[SLICE_W-1:0]}]) return 1'b0;
            return 1'b1;
        endfunction

        function void scroll_rows();
            for (int i = 0; i < SCR_DEPTH - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = SCR_DEPTH - COLS; i < SCR_DEPTH; i++) screen[i] = '0;
        endfunction

        // print at cursor, wrap at line end, scroll off the bottom
        function void put_char(logic [CODE_W-1:0] c);
            if (cur_col >= COLS) cur_col = COLS - 1;
            if (cur_row >= ROWS) cur_row = ROWS - 1;
            screen[cur_row * COLS + cur_col] = c;
            cur_col++;
            if (cur_col >= COLS)
            begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= ROWS)
                begin
                    scroll_rows();
                    cur_row = ROWS - 1;
                end
            end
        endfunction

        // one line tick: advance counter, pick sync, queue the scanline bytes
        function void render_line();
            int         rel;
            int         cy;
            int         slice;
            scan_byte_t b;
            line_cnt      = line_cnt + 1'b1;
            b.line_number = line_cnt;
            b.sync_width  = (line_cnt >= vs_first && line_cnt <= vs_last) ?
                            long_sync : short_sync;
            rel = int'(line_cnt) - int'(first_vis);
            if (rel >= 0 && rel < VIS_LINES)
            begin
                cy            = rel / SLICES;
                slice         = rel % SLICES;
                b.pixel_valid = 1'b1;
                b.last_item   = 1'b0;
                for (int x = 0; x < COLS; x++)
                begin
                    b.pattern = glyph[{screen[cy * COLS + x], slice[SLICE_W-1:0]}];
                    expected_bytes.push_back(b);
                end
            end
            else
            begin
                b.pixel_valid = 1'b0;
            end
            b.pattern   = '0;
            b.last_item = 1'b1;
            expected_bytes.push_back(b);
            if (line_cnt > last_line) line_cnt = '0;
        endfunction

        function void note_item(char_item_t it);
            case (it.kind)
                KIND_TICK:   render_line();
                KIND_PRINT:  put_char(it.char_code);
                KIND_CURSOR:
                begin
                    cur_col = (it.col >= COLS) ? COLS - 1 : int'(it.col);
                    cur_row = (it.row >= ROWS) ? ROWS - 1 : int'(it.row);
                end
                KIND_CLEAR:  foreach (screen[i]) screen[i] = '0;
                KIND_SCROLL: scroll_rows();
                KIND_FONT:
                begin
                    glyph[it.font_addr]     = it.font_data;
                    glyph_set[it.font_addr] = 1'b1;
                end
                KIND_CELL:
                    if (it.col < COLS && it.row < ROWS)
                        screen[it.row * COLS + it.col] = it.char_code;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, msg);
        endtask

        task check_result(scan_byte_t got);
            scan_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte, line %0d", got.line_number));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.line_number !== want.line_number)
                report($sformatf("line_number %0d, want %0d",
                                 got.line_number, want.line_number));
            if (got.sync_width !== want.sync_width)
                report($sformatf("line %0d sync_width %0d, want %0d",
                                 want.line_number, got.sync_width, want.sync_width));
            if (got.pixel_valid !== want.pixel_valid)
                report($sformatf("line %0d pixel_valid %b, want %b",
                                 want.line_number, got.pixel_valid, want.pixel_valid));
            if (got.pattern !== want.pattern)
                report($sformatf("line %0d pattern %h, want %h",
                                 want.line_number, got.pattern, want.pattern));
            if (got.last_item !== want.last_item)
                report($sformatf("line %0d tlast %b, want %b",
                                 want.line_number, got.last_item, want.last_item));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals, instance
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIRST_VISIBLE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = KIND_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    scanline_board board;
    bit            tx_steady = 1'b0;
    bit            rx_steady = 1'b0;
    int            rx_stall  = 0;
    int            sent      = 0;
    int unsigned   cycles    = 0;

    always #CLK_HALF clk = ~clk;

    text_mode_video_character_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // idle length per transaction, with occasional stretches of no idling
    function automatic int pick_gap(inout bit steady);
        if ($urandom_range(0, 15) == 0) steady = !steady;
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic char_item_t make_item(logic [KIND_W-1:0] kind,
                                             logic [CODE_W-1:0] code,
                                             logic [POS_W-1:0] col,
                                             logic [POS_W-1:0] row,
                                             logic [GLYPH_AW-1:0] faddr,
                                             logic [7:0] fdata);
        char_item_t it;
        it.kind      = kind;
        it.char_code = code;
        it.col       = col;
        it.row       = row;
        it.font_addr = faddr;
        it.font_data = fdata;
        return it;
    endfunction

    // random code, fallen back to a loaded one if its glyph is incomplete
    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] c;
        c = CODE_W'($urandom_range(0, 255));
        if (!board.code_ready(c)) c = BASE_CODES[$urandom_range(0, BASE_COUNT - 1)];
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check accepted bytes, stall at random
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_sink
        scan_byte_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.line_number = m_tdata[LINE_W-1:0];
                got.sync_width  = m_tdata[LINE_W+SYNC_W-1:LINE_W];
                got.pixel_valid = m_tuser[0];
                got.pattern     = m_tdata[LINE_W+SYNC_W+7:LINE_W+SYNC_W];
                got.last_item   = m_tlast;
                board.check_result(got);
                rx_stall = pick_gap(rx_steady);
            end
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall = rx_stall - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycles, board.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    task automatic send_item(char_item_t it);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {3'b000, it.font_data, it.font_addr, it.row, it.col, it.char_code};
        s_tuser  <= it.kind;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        board.note_item(it);
        if (it.kind != KIND_UNUSED) sent++;
    endtask

    // all eight slices of one glyph
    task automatic load_glyph(logic [CODE_W-1:0] code);
        for (int s = 0; s < SLICES; s++)
            send_item(make_item(KIND_FONT, 8'h00, 5'd0, 5'd0, {code, s[SLICE_W-1:0]},
                                8'($urandom_range(0, 255))));
    endtask

    task automatic send_random(int tick_pct);
        char_item_t it;
        int         roll;
        it = make_item(KIND_TICK, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 11'($urandom_range(0, 2047)),
                       8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < tick_pct)
        begin
            send_item(it);
            return;
        end
        roll = $urandom_range(0, 99);
        if (roll < 36)
        begin
            it.kind      = KIND_PRINT;
            it.char_code = pick_code();
        end
        else if (roll < 60)
        begin
            it.kind      = KIND_CELL;
            it.char_code = pick_code();
            if ($urandom_range(0, 6) != 0) it.row = 5'($urandom_range(0, ROWS - 1));
        end
        else if (roll < 73)
        begin
            it.kind = KIND_CURSOR;
        end
        else if (roll < 82)
        begin
            it.kind = KIND_FONT;
        end
        else if (roll < 89)
        begin
            load_glyph(8'($urandom_range(0, 255)));
            return;
        end
        else if (roll < 96)
        begin
            it.kind = KIND_SCROLL;
        end
        else
        begin
            it.kind = KIND_CLEAR;
        end
        send_item(it);
    endtask

    // wait for every owed byte plus the tail of a non-tick transaction
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_timing(input logic [CFG_DATA_W-1:0] fv, ll, vf, vl, ss, ls);
        logic [CFG_DATA_W-1:0] vals [6];
        logic [CFG_IDX_W-1:0]  regs [6];
        vals = '{fv, ll, vf, vl, ss, ls};
        regs = '{CFG_FIRST_VISIBLE, CFG_LAST_LINE, CFG_VSYNC_FIRST,
                 CFG_VSYNC_LAST, CFG_SHORT_SYNC, CFG_LONG_SYNC};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            board.set_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count, int tick_pct);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at) send_random(tick_pct);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int vf;
        int fv;
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base font so every screen cell renders from written glyph data
        for (int i = 0; i < BASE_COUNT; i++) load_glyph(BASE_CODES[i]);

        // directed: reset timing, vsync window, wrap/scroll, range limits
        repeat (6) send_item(make_item(KIND_TICK, 8'h00, 5'd0, 5'd0, 11'd0, 8'h00));
        send_item(make_item(KIND_PRINT,  8'hFF, 5'd0,  5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_PRINT,  8'h00, 5'd0,  5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_CURSOR, 8'h00, 5'd31, 5'd31, 11'd0, 8'h00));
        send_item(make_item(KIND_PRINT,  8'h55, 5'd0,  5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_CELL,   8'hAA, 5'd31, 5'd23, 11'd0, 8'h00));
        send_item(make_item(KIND_CELL,   8'hFF, 5'd0,  5'd24, 11'd0, 8'h00));
        send_item(make_item(KIND_CELL,   8'h0F, 5'd31, 5'd31, 11'd0, 8'h00));
        send_item(make_item(KIND_CURSOR, 8'h00, 5'd0,  5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_FONT,   8'h00, 5'd0,  5'd0,  11'h7FF, 8'hFF));
        send_item(make_item(KIND_FONT,   8'h00, 5'd0,  5'd0,  11'h000, 8'h00));
        send_item(make_item(KIND_CLEAR,  8'h00, 5'd0,  5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_SCROLL, 8'h00, 5'd0,  5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_UNUSED, 8'hFF, 5'd31, 5'd31, 11'h7FF, 8'hFF));
        send_item(make_item(KIND_PRINT,  8'hAA, 5'd0,  5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_CURSOR, 8'h00, 5'd31, 5'd0,  11'd0, 8'h00));
        send_item(make_item(KIND_PRINT,  8'hF0, 5'd0,  5'd0,  11'd0, 8'h00));
        settle();

        // visible from line 1, long sync everywhere
        program_timing(12'd0, 12'd60, 12'd0, 12'd511, 12'd0, 12'd4095);
        random_phase(20, 50);
        settle();

        // short frame, empty vsync window
        program_timing(12'd8, 12'd1, 12'd511, 12'd0, 12'd4095, 12'd0);
        random_phase(12, 35);
        settle();

        // random window settings
        fv = $urandom_range(0, 16);
        vf = $urandom_range(0, 20);
        program_timing(12'(fv), 12'(fv + $urandom_range(60, 200)), 12'(vf),
                       12'(vf + $urandom_range(0, 10)), 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)));
        random_phase(24, 45);
        settle();

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hdl/tmcg_pkg.sv
hdl/tmcg_ram.sv
hdl/tmcg_ctrl.sv
hdl/tmcg_dp.sv
hdl/text_mode_video_character_generator.sv
sim/tb_text_mode_video_character_generator.sv
